/* design/display_scale_table_unit_defines.svh */
// Assertion macros used by the display scale table unit controller
`ifndef DISPLAY_SCALE_TABLE_UNIT_DEFINES_SVH
`define DISPLAY_SCALE_TABLE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// check a property on every rising clock edge outside reset
`define DST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("display scale table: check failed");

// check that a condition implies a consequence in the same cycle
`define DST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("display scale table: implication failed");

`else

`define DST_ASSERT(label, clk, rst, prop)
`define DST_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

/* design/dst_pkg.sv */
// Types, constants and helper functions of the display scale table unit
package dst_pkg;

   localparam int MAX_DISPLAYS = 4;

   // field widths
   localparam int KIND_W   = 3;
   localparam int ID_W     = 2;
   localparam int PHYS_W   = 14;
   localparam int DPI_W    = 10;
   localparam int SCALE_W  = 9;
   localparam int COORD_W  = 16;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 18;
   localparam int LOG_W    = 14;

   // table indexing
   localparam int IDX_W = (MAX_DISPLAYS > 1) ? $clog2(MAX_DISPLAYS) : 1;
   localparam int CNT_W = $clog2(MAX_DISPLAYS + 1);
   localparam int EXT_W = ID_W + CNT_W;

   // arithmetic widths: |c*s + 50| stays below 2**24
   localparam int NUM_W     = 25;
   localparam int MAG_W     = NUM_W - 1;
   localparam int OPA_W     = COORD_W + 1;
   localparam int OPB_W     = SCALE_W + 1;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int DIV_CNT_W = $clog2(MAG_W);

   // stream packing
   localparam int REQ_ID_LSB    = 0;
   localparam int REQ_PW_LSB    = REQ_ID_LSB + ID_W;
   localparam int REQ_PH_LSB    = REQ_PW_LSB + PHYS_W;
   localparam int REQ_DPI_LSB   = REQ_PH_LSB + PHYS_W;
   localparam int REQ_NS_LSB    = REQ_DPI_LSB + DPI_W;
   localparam int REQ_COORD_LSB = REQ_NS_LSB + SCALE_W;
   localparam int REQ_BITS      = REQ_COORD_LSB + COORD_W;
   localparam int REQ_DATA_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS      = STATUS_W + VALUE_W + 2 * LOG_W;
   localparam int RSP_DATA_W    = ((RSP_BITS + 7) / 8) * 8;

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_SCALE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SCALE_UP   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SCALE_DOWN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SIZE_QUERY = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   // scale limits and rounding constants
   localparam logic [SCALE_W-1:0] SCALE_DEFAULT = 9'd100;
   localparam logic [SCALE_W-1:0] PCT_BASE      = 9'd100;
   localparam logic [SCALE_W-1:0] SCALE_MIN     = 9'd100;
   localparam logic [SCALE_W-1:0] SCALE_MAX     = 9'd400;
   localparam logic [SCALE_W-1:0] UP_ROUND      = 9'd50;

   // DPI band edges
   localparam logic [DPI_W-1:0] DPI_BAND_125 = 10'd108;
   localparam logic [DPI_W-1:0] DPI_BAND_150 = 10'd132;
   localparam logic [DPI_W-1:0] DPI_BAND_175 = 10'd156;
   localparam logic [DPI_W-1:0] DPI_BAND_200 = 10'd180;
   localparam logic [DPI_W-1:0] DPI_BAND_250 = 10'd216;
   localparam logic [DPI_W-1:0] DPI_BAND_300 = 10'd264;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MULT,
      ST_DIVLD,
      ST_DIVIDE,
      ST_FINISH
   } dst_state_type;

   typedef enum logic [1:0] {
      PASS_WIDTH,
      PASS_HEIGHT,
      PASS_COORD
   } dst_pass_type;

   typedef struct packed {
      logic         capture;
      logic         decode;
      logic         mult;
      logic         div_start;
      logic         writeback;
      logic         load_out;
      dst_pass_type pass;
   } dst_cmd_type;

   typedef struct packed {
      logic recompute;
      logic convert;
      logic div_busy;
   } dst_stat_type;

   // scale percent chosen from the display's DPI
   function automatic logic [SCALE_W-1:0] band_scale(input logic [DPI_W-1:0] dpi);
      logic [SCALE_W-1:0] s;
      if (dpi <= DPI_BAND_125) begin
         s = 9'd100;
      end else if (dpi <= DPI_BAND_150) begin
         s = 9'd125;
      end else if (dpi <= DPI_BAND_175) begin
         s = 9'd150;
      end else if (dpi <= DPI_BAND_200) begin
         s = 9'd175;
      end else if (dpi <= DPI_BAND_250) begin
         s = 9'd200;
      end else if (dpi <= DPI_BAND_300) begin
         s = 9'd250;
      end else begin
         s = 9'd300;
      end
      return s;
   endfunction

endpackage

/* design/dst_div.sv */
// Restoring signed divider, one quotient bit a cycle, truncating toward zero
module dst_div
   import dst_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [NUM_W-1:0]   num,
   input  logic        [SCALE_W-1:0] den,
   output logic                      busy,
   output logic signed [NUM_W-1:0]   quot
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic [MAG_W-1:0]     q_ff, q_in;
   logic [SCALE_W-1:0]   rem_ff, rem_in;
   logic [SCALE_W-1:0]   den_ff, den_in;

   logic [SCALE_W:0]     shifted;
   logic [SCALE_W:0]     diff;
   logic                 fits;
   logic [NUM_W-1:0]     num_neg;
   logic [NUM_W-1:0]     q_ext;

   always_comb begin
      shifted = {rem_ff, q_ff[MAG_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      num_neg = -num;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[NUM_W-1];
         q_in    = num[NUM_W-1] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         q_in   = {q_ff[MAG_W-2:0], fits};
         rem_in = fits ? diff[SCALE_W-1:0] : shifted[SCALE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign q_ext = {1'b0, q_ff};
   assign quot  = neg_ff ? -q_ext : q_ext;
   assign busy  = busy_ff;

endmodule

/* design/dst_dpath.sv */
// Datapath: display table, scale multiplier, divider and result registers
module dst_dpath
   import dst_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dst_cmd_type                cmd,
   output dst_stat_type               stat,
   input  logic        [KIND_W-1:0]   in_kind,
   input  logic        [ID_W-1:0]     in_screen_id,
   input  logic        [PHYS_W-1:0]   in_phys_width,
   input  logic        [PHYS_W-1:0]   in_phys_height,
   input  logic        [DPI_W-1:0]    in_dots_per_inch,
   input  logic        [SCALE_W-1:0]  in_new_scale,
   input  logic signed [COORD_W-1:0]  in_coordinate,
   output logic        [STATUS_W-1:0] out_status,
   output logic signed [VALUE_W-1:0]  out_value,
   output logic        [LOG_W-1:0]    out_view_width,
   output logic        [LOG_W-1:0]    out_view_height
);

   // captured word
   logic        [KIND_W-1:0]  kind_ff;
   logic        [ID_W-1:0]    id_ff;
   logic        [PHYS_W-1:0]  pw_ff;
   logic        [PHYS_W-1:0]  ph_ff;
   logic        [DPI_W-1:0]   dpi_ff;
   logic        [SCALE_W-1:0] ns_ff;
   logic signed [COORD_W-1:0] coord_ff;
   logic        [IDX_W-1:0]   idx_ff, idx_in;

   // display table
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SCALE_W-1:0] scale_store_ff [MAX_DISPLAYS];
   logic [PHYS_W-1:0]  pw_store_ff    [MAX_DISPLAYS];
   logic [PHYS_W-1:0]  ph_store_ff    [MAX_DISPLAYS];
   logic [LOG_W-1:0]   lw_store_ff    [MAX_DISPLAYS];
   logic [LOG_W-1:0]   lh_store_ff    [MAX_DISPLAYS];

   // working and result registers
   logic        [SCALE_W-1:0]  scale_ff;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic        [SCALE_W-1:0]  den_ff, den_in;
   logic        [STATUS_W-1:0] res_status_ff;
   logic        [VALUE_W-1:0]  res_value_ff;
   logic        [LOG_W-1:0]    res_lw_ff;
   logic        [LOG_W-1:0]    res_lh_ff;
   logic        [STATUS_W-1:0] out_status_ff;
   logic        [VALUE_W-1:0]  out_value_ff;
   logic        [LOG_W-1:0]    out_lw_ff;
   logic        [LOG_W-1:0]    out_lh_ff;

   logic [EXT_W-1:0]    in_id_ext, cnt_ext, id_ext;
   logic                full, known, scale_ok;
   logic                reg_ok, set_ok, conv, query;
   logic [STATUS_W-1:0] status_dec;
   logic [SCALE_W-1:0]  scale_dec;

   logic                      is_up;
   logic signed [OPA_W-1:0]   opa;
   logic signed [OPB_W-1:0]   opb;
   logic signed [PROD_W-1:0]  prod, addend, sum;
   logic                      div_busy;
   logic signed [NUM_W-1:0]   quot;

   // table slot: the next free entry for register, else the addressed one
   always_comb begin
      in_id_ext = EXT_W'(in_screen_id);
      cnt_ext   = EXT_W'(count_ff);
      idx_in    = (in_kind == KIND_REGISTER) ? cnt_ext[IDX_W-1:0] : in_id_ext[IDX_W-1:0];
   end

   always_comb begin
      id_ext   = EXT_W'(id_ff);
      full     = count_ff >= CNT_W'(MAX_DISPLAYS);
      known    = (id_ext < cnt_ext) && (id_ext < EXT_W'(MAX_DISPLAYS));
      scale_ok = (ns_ff >= SCALE_MIN) && (ns_ff <= SCALE_MAX);
      reg_ok   = (kind_ff == KIND_REGISTER) && !full;
      set_ok   = (kind_ff == KIND_SET_SCALE) && known && scale_ok;
      conv     = (kind_ff == KIND_SCALE_UP) || (kind_ff == KIND_SCALE_DOWN);
      query    = (kind_ff == KIND_SIZE_QUERY) && known;

      case (kind_ff)
         KIND_REGISTER:   status_dec = full ? STATUS_FULL : STATUS_OK;
         KIND_SET_SCALE:  status_dec = set_ok ? STATUS_OK : STATUS_BAD;
         KIND_SCALE_UP:   status_dec = STATUS_OK;
         KIND_SCALE_DOWN: status_dec = STATUS_OK;
         KIND_SIZE_QUERY: status_dec = known ? STATUS_OK : STATUS_BAD;
         default:         status_dec = STATUS_BAD;
      endcase

      if (reg_ok) begin
         scale_dec = band_scale(dpi_ff);
      end else if (set_ok) begin
         scale_dec = ns_ff;
      end else if (known) begin
         scale_dec = scale_store_ff[idx_ff];
      end else begin
         scale_dec = SCALE_DEFAULT;
      end

      count_in = reg_ok ? count_ff + 1'b1 : count_ff;
   end

   assign stat.recompute = reg_ok || set_ok;
   assign stat.convert   = conv;
   assign stat.div_busy  = div_busy;

   // numerator: up is c*s + 50 over 100; down and the size passes are x*100 + s/2 over s
   always_comb begin
      is_up = (cmd.pass == PASS_COORD) && (kind_ff == KIND_SCALE_UP);
      case (cmd.pass)
         PASS_WIDTH:  opa = $signed(OPA_W'(pw_store_ff[idx_ff]));
         PASS_HEIGHT: opa = $signed(OPA_W'(ph_store_ff[idx_ff]));
         PASS_COORD:  opa = OPA_W'(coord_ff);
         default:     opa = '0;
      endcase
      opb    = $signed({1'b0, is_up ? scale_ff : PCT_BASE});
      prod   = opa * opb;
      addend = is_up ? $signed(PROD_W'(UP_ROUND)) : $signed(PROD_W'(scale_ff >> 1));
      sum    = prod + addend;
      num_in = sum[NUM_W-1:0];
      den_in = is_up ? PCT_BASE : scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.decode) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= in_kind;
         id_ff    <= in_screen_id;
         pw_ff    <= in_phys_width;
         ph_ff    <= in_phys_height;
         dpi_ff   <= in_dots_per_inch;
         ns_ff    <= in_new_scale;
         coord_ff <= in_coordinate;
         idx_ff   <= idx_in;
      end

      if (cmd.decode) begin
         res_status_ff <= status_dec;
         res_value_ff  <= reg_ok ? VALUE_W'(count_ff) : '0;
         res_lw_ff     <= query ? lw_store_ff[idx_ff] : '0;
         res_lh_ff     <= query ? lh_store_ff[idx_ff] : '0;
         scale_ff      <= scale_dec;
         if (reg_ok) begin
            pw_store_ff[idx_ff] <= pw_ff;
            ph_store_ff[idx_ff] <= ph_ff;
         end
         if (reg_ok || set_ok) begin
            scale_store_ff[idx_ff] <= scale_dec;
         end
      end

      if (cmd.mult) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end

      if (cmd.writeback) begin
         case (cmd.pass)
            PASS_WIDTH: begin
               res_lw_ff           <= quot[LOG_W-1:0];
               lw_store_ff[idx_ff] <= quot[LOG_W-1:0];
            end
            PASS_HEIGHT: begin
               res_lh_ff           <= quot[LOG_W-1:0];
               lh_store_ff[idx_ff] <= quot[LOG_W-1:0];
            end
            PASS_COORD: begin
               res_value_ff <= quot[VALUE_W-1:0];
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
         out_lw_ff     <= res_lw_ff;
         out_lh_ff     <= res_lh_ff;
      end
   end

   dst_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .quot  (quot)
   );

   assign out_status      = out_status_ff;
   assign out_value       = $signed(out_value_ff);
   assign out_view_width  = out_lw_ff;
   assign out_view_height = out_lh_ff;

endmodule

/* design/dst_ctrl.sv */
// Controller: sequences decode, multiply, divide passes and result hand-off
`include "display_scale_table_unit_defines.svh"

module dst_ctrl
   import dst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  dst_stat_type stat,
   output dst_cmd_type  cmd
);

   dst_state_type state_ff, state_in;
   dst_pass_type  pass_ff, pass_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= PASS_COORD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.pass      = pass_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.recompute) begin
               pass_in  = PASS_WIDTH;
               state_in = ST_MULT;
            end else if (stat.convert) begin
               pass_in  = PASS_COORD;
               state_in = ST_MULT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIVLD;
         end
         ST_DIVLD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!stat.div_busy) begin
               cmd.writeback = 1'b1;
               if (pass_ff == PASS_WIDTH) begin
                  pass_in  = PASS_HEIGHT;
                  state_in = ST_MULT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // hold until the output register is free or drains this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `DST_ASSERT_IMPL(a_accept_div_idle, clock, reset, req_tvalid && req_tready, !stat.div_busy)
   `DST_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
   `DST_ASSERT(a_mult_entry, clock, reset, (state_ff == ST_MULT) |-> ($past(state_ff) == ST_DECODE || $past(state_ff) == ST_DIVIDE))
   `DST_ASSERT(a_height_follows_width, clock, reset, (state_ff == ST_DIVIDE && !stat.div_busy && pass_ff == PASS_WIDTH) |=> (state_ff == ST_MULT && pass_ff == PASS_HEIGHT))

endmodule

/* design/display_scale_table_unit.sv */
// Top level of the display scale table unit: stream ports, controller and datapath
//
// Keeps a table of up to MAX_DISPLAYS displays (physical size, scale percent,
// logical size) and serves one request word at a time, returning exactly one
// response word for each. The kind travels in req_tuser: register appends a
// display with a scale taken from its DPI band, set scale replaces an entry's
// scale (100..400), scale up and scale down convert a signed coordinate with the
// entry's scale (100 for an id not yet registered), size query reads an entry's
// logical size. Logical sizes and conversions go through one signed divider that
// yields one quotient bit per cycle, after a registered multiply. For register
// and set scale, width and height take a divider pass each. The response sits in
// an output register, so a new request is taken while an earlier response still
// waits for rsp_tready; status 1 means table full, 2 a bad id, scale or kind,
// and then the other response fields are zero.
module display_scale_table_unit
   import dst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request words
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // screen_id, phys_width, phys_height, dots_per_inch, new_scale,
   // coordinate, zero padding (lowest bit first)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [KIND_W-1:0]     req_tuser,
   // response words
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, value, view_width, view_height (lowest bit first)
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   dst_cmd_type  cmd;
   dst_stat_type stat;

   logic        [ID_W-1:0]     req_screen_id;
   logic        [PHYS_W-1:0]   req_phys_width;
   logic        [PHYS_W-1:0]   req_phys_height;
   logic        [DPI_W-1:0]    req_dots_per_inch;
   logic        [SCALE_W-1:0]  req_new_scale;
   logic signed [COORD_W-1:0]  req_coordinate;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic        [LOG_W-1:0]    rsp_view_width;
   logic        [LOG_W-1:0]    rsp_view_height;

   // split the request word into its fields
   assign req_screen_id     = req_tdata[REQ_ID_LSB    +: ID_W];
   assign req_phys_width    = req_tdata[REQ_PW_LSB    +: PHYS_W];
   assign req_phys_height   = req_tdata[REQ_PH_LSB    +: PHYS_W];
   assign req_dots_per_inch = req_tdata[REQ_DPI_LSB   +: DPI_W];
   assign req_new_scale     = req_tdata[REQ_NS_LSB    +: SCALE_W];
   assign req_coordinate    = $signed(req_tdata[REQ_COORD_LSB +: COORD_W]);

   dst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dst_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_kind          (req_tuser),
      .in_screen_id     (req_screen_id),
      .in_phys_width    (req_phys_width),
      .in_phys_height   (req_phys_height),
      .in_dots_per_inch (req_dots_per_inch),
      .in_new_scale     (req_new_scale),
      .in_coordinate    (req_coordinate),
      .out_status       (rsp_status),
      .out_value        (rsp_value),
      .out_view_width   (rsp_view_width),
      .out_view_height  (rsp_view_height)
   );

   // pack the response word, zero-filled up to whole bytes
   assign rsp_tdata = RSP_DATA_W'({rsp_view_height, rsp_view_width,
                                   rsp_value, rsp_status});

endmodule
